### hdl/ffd_pkg.sv
`timescale 1ns / 1ps

package ffd_pkg;

	localparam int MAX_FIELDS = 16;
	localparam int IDX_W = $clog2(MAX_FIELDS);
	localparam int CNT_W = IDX_W + 1;

	// stream commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_DESC  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// configuration register indexes
	localparam logic REG_NUM_FIELDS = 1'b0;
	localparam logic REG_DEFAULT_BE = 1'b1;

	// field type codes
	localparam logic [3:0] TY_U8   = 4'd0;
	localparam logic [3:0] TY_U16  = 4'd1;
	localparam logic [3:0] TY_U32  = 4'd2;
	localparam logic [3:0] TY_I8   = 4'd3;
	localparam logic [3:0] TY_I16  = 4'd4;
	localparam logic [3:0] TY_I32  = 4'd5;
	localparam logic [3:0] TY_BOOL = 4'd6;
	localparam logic [3:0] TY_F32  = 4'd7;
	localparam logic [3:0] TY_F64  = 4'd8;

	localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;

	// descriptor layout word: length, type, byte order, padding
	typedef struct packed {
		logic       padding;
		logic       big_endian;
		logic [3:0] ftype;
		logic [7:0] length;
	} layout_t;

	// length used when the descriptor gives zero
	function automatic logic [7:0] default_len(input logic [3:0] t);
		logic [7:0] r;
		case (t)
			TY_U16, TY_I16:         r = 8'd2;
			TY_U32, TY_I32, TY_F32: r = 8'd4;
			TY_F64:                 r = 8'd8;
			default:                r = 8'd1;
		endcase
		return r;
	endfunction

endpackage

### hdl/ffd_in_if.sv
`timescale 1ns / 1ps

interface ffd_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [7:0]         data_byte;
	logic [3:0]         desc_index;
	logic [7:0]         desc_length;
	logic [3:0]         desc_type;
	logic               desc_big_endian;
	logic               desc_padding;
	logic signed [31:0] desc_scale;
	logic signed [63:0] desc_offset;

	modport source (output valid, command, data_byte, desc_index, desc_length, desc_type,
		desc_big_endian, desc_padding, desc_scale, desc_offset, input ready);
	modport sink (input valid, command, data_byte, desc_index, desc_length, desc_type,
		desc_big_endian, desc_padding, desc_scale, desc_offset, output ready);
endinterface

### hdl/ffd_out_if.sv
`timescale 1ns / 1ps

interface ffd_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         field_index;
	logic signed [63:0] field_value;
	logic               saturated;
	logic [31:0]        frame_number;
	logic               last;

	modport source (output valid, field_index, field_value, saturated, frame_number, last,
		input ready);
	modport sink (input valid, field_index, field_value, saturated, frame_number, last,
		output ready);
endinterface

### hdl/ffd_cfg_if.sv
`timescale 1ns / 1ps

interface ffd_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [4:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/frame_field_decoder.sv
`timescale 1ns / 1ps

// Stream byte: accepted while idle, then the descriptor is read; a byte that ends a data field
// then goes through decode (convert, two multiply passes on one 32x32 multiplier, scale, offset).
// Frame end: each descriptor in use is read and checked to drain results from the value memory,
// then a final step; the drain is stalled by the result port. Descriptor writes and clears finish while idle.
// Reset clears control state and the descriptor valid bits (unwritten descriptors read
// as zero); no clearing pass, the block accepts words right after reset.
module frame_field_decoder (
	input  logic       clk,
	input  logic       arst_n,
	ffd_in_if.sink     item,
	ffd_out_if.source  result,
	ffd_cfg_if.sink    cfg
);
	import ffd_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CONV, S_MLO, S_MHI, S_SCL, S_ADD, S_DRD, S_DCHK, S_DFIN
	} state_t;

	state_t state_q;

	// descriptor and value memories
	layout_t     lay_mem  [MAX_FIELDS];
	logic [31:0] gain_mem [MAX_FIELDS];
	logic [63:0] bias_mem [MAX_FIELDS];
	logic [64:0] dec_mem  [MAX_FIELDS];

	layout_t     lay_rd_q;
	logic [31:0] gain_rd_q;
	logic [63:0] bias_rd_q;
	logic [64:0] dec_rd_q;
	logic        vld_rd_q;

	logic [MAX_FIELDS-1:0] vld_q;
	logic [4:0]            num_q;
	logic                  dbe_q;
	logic [CNT_W-1:0]      cur_q;
	logic [7:0]            bif_q;
	logic [63:0]           acc_q;
	logic [31:0]           fcnt_q;
	logic [7:0]            byte_q;
	logic [3:0]            typ_q;
	logic [63:0]           v_q;
	logic                  sat_q;
	logic [63:0]           plo_q;
	logic [63:0]           phi_q;
	logic [CNT_W-1:0]      di_q;
	logic                  pend_q;
	logic [IDX_W-1:0]      pend_idx_q;
	logic [63:0]           pend_val_q;
	logic                  pend_sat_q;

	logic        ovalid_q;
	logic [3:0]  oidx_q;
	logic [63:0] oval_q;
	logic        osat_q;
	logic [31:0] ofn_q;
	logic        olast_q;

	logic [CNT_W-1:0] n;
	logic             item_acc;
	logic             cfg_acc;
	logic             desc_we;
	logic [7:0]       dlen;
	layout_t          desc_lay;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [CNT_W-1:0] cur_eff;
	layout_t          lay;
	logic [7:0]       len;
	logic             be;
	logic [7:0]       bif_nx;
	logic [63:0]      acc_nx;
	logic [CNT_W-1:0] cur_nx;
	logic [CNT_W-1:0] di_nx;
	logic [31:0]      gain_use;
	logic [63:0]      bias_use;
	logic [63:0]      vmag;
	logic [31:0]      gmag;
	logic [31:0]      mul_a;
	logic [63:0]      prod;
	logic             sneg;
	logic [63:0]      slim;
	logic [63:0]      st;
	logic [63:0]      sum;
	logic             aovf;
	logic [63:0]      afin;
	logic             can_load;
	logic             out_load;
	logic [63:0]      conv_q;
	logic             conv_sat;

	ffd_to_fixed u_conv (
		.raw   (acc_q),
		.ftype (typ_q),
		.q     (conv_q),
		.sat   (conv_sat)
	);

	// register writes take priority over stream words, both only while idle
	assign item.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg.ready  = (state_q == S_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign cfg_acc    = cfg.valid && cfg.ready;
	assign can_load   = !ovalid_q || result.ready;

	// load the output register with the held result
	assign out_load = pend_q && can_load
		&& (((state_q == S_DCHK) && !lay.padding) || (state_q == S_DFIN));

	assign result.valid        = ovalid_q;
	assign result.field_index  = oidx_q;
	assign result.field_value  = oval_q;
	assign result.saturated    = osat_q;
	assign result.frame_number = ofn_q;
	assign result.last         = olast_q;

	// fields in use, capped at the table depth
	assign n = (num_q > 5'(MAX_FIELDS)) ? CNT_W'(MAX_FIELDS) : CNT_W'(num_q);
	assign cur_eff = (cur_q >= n) ? '0 : cur_q;

	// build the stored descriptor
	always_comb begin
		dlen = (item.desc_length == 8'd0) ? default_len(item.desc_type) : item.desc_length;
		if (!item.desc_padding && dlen > 8'd8)
			dlen = 8'd8;
		desc_lay = '{padding: item.desc_padding, big_endian: item.desc_big_endian,
			ftype: item.desc_type, length: dlen};
	end
	assign desc_we = item_acc && (item.command == CMD_DESC);

	// memory read port: current field while streaming, sweep index while draining
	assign rd_en   = (item_acc && item.command == CMD_BYTE && n != '0) || (state_q == S_DRD);
	assign rd_addr = (state_q == S_DRD) ? di_q[IDX_W-1:0] : cur_eff[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (desc_we) begin
			lay_mem[item.desc_index]  <= desc_lay;
			gain_mem[item.desc_index] <= item.desc_scale;
			bias_mem[item.desc_index] <= item.desc_offset;
		end
		if (state_q == S_ADD)
			dec_mem[cur_q[IDX_W-1:0]] <= {sat_q | aovf, afin};
		if (rd_en) begin
			lay_rd_q  <= lay_mem[rd_addr];
			gain_rd_q <= gain_mem[rd_addr];
			bias_rd_q <= bias_mem[rd_addr];
			dec_rd_q  <= dec_mem[rd_addr];
		end
	end

	// descriptor view, zero where never written
	always_comb begin
		lay      = vld_rd_q ? lay_rd_q : '0;
		gain_use = vld_rd_q ? gain_rd_q : 32'd0;
		bias_use = vld_rd_q ? bias_rd_q : 64'd0;
		len      = (lay.length == 8'd0) ? 8'd1 : lay.length;
		be       = lay.big_endian | dbe_q;
		bif_nx   = bif_q + 8'd1;
		acc_nx   = acc_q;
		if (!lay.padding) begin
			if (be)
				acc_nx = {acc_q[55:0], byte_q};
			else if (bif_q < 8'd8)
				acc_nx = acc_q | ({56'b0, byte_q} << {bif_q[2:0], 3'b000});
		end
		cur_nx = cur_q + 1'b1;
		di_nx  = di_q + 1'b1;
	end

	// gain multiply on magnitudes, low then high half of the value
	always_comb begin
		vmag  = v_q[63] ? (64'd0 - v_q) : v_q;
		gmag  = gain_use[31] ? (32'd0 - gain_use) : gain_use;
		mul_a = (state_q == S_MLO) ? vmag[31:0] : vmag[63:32];
		prod  = mul_a * gmag;
		sneg  = v_q[63] ^ gain_use[31];
		slim  = sneg ? Q_MIN : Q_MAX;
		st    = {phi_q[47:0], 16'b0} + {16'b0, plo_q[63:16]};
		sum   = v_q + bias_use;
		aovf  = ((v_q ^ sum) & (bias_use ^ sum)) >> 63 != 64'd0;
		afin  = aovf ? (v_q[63] ? Q_MIN : Q_MAX) : sum;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
			num_q    <= '0;
			dbe_q    <= 1'b0;
			cur_q    <= '0;
			bif_q    <= '0;
			acc_q    <= '0;
			fcnt_q   <= '0;
			di_q     <= '0;
			pend_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_load)
				ovalid_q <= 1'b1;
			else if (result.ready)
				ovalid_q <= 1'b0;
			if (rd_en)
				vld_rd_q <= vld_q[rd_addr];
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						case (item.command)
							CMD_BYTE: begin
								if (n != '0) begin
									byte_q <= item.data_byte;
									if (cur_q >= n) begin
										cur_q <= '0;
										bif_q <= '0;
										acc_q <= '0;
									end
									state_q <= S_RD;
								end
							end
							CMD_DESC: begin
								vld_q[item.desc_index] <= 1'b1;
								cur_q <= '0;
								bif_q <= '0;
								acc_q <= '0;
							end
							CMD_CLEAR: begin
								cur_q  <= '0;
								bif_q  <= '0;
								acc_q  <= '0;
								fcnt_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_RD: begin
					if (bif_nx < len) begin
						acc_q   <= acc_nx;
						bif_q   <= bif_nx;
						state_q <= S_IDLE;
					end else if (!lay.padding) begin
						acc_q   <= acc_nx;
						typ_q   <= lay.ftype;
						state_q <= S_CONV;
					end else begin
						cur_q <= cur_nx;
						bif_q <= '0;
						acc_q <= '0;
						if (cur_nx < n) begin
							state_q <= S_IDLE;
						end else begin
							di_q    <= '0;
							pend_q  <= 1'b0;
							state_q <= S_DRD;
						end
					end
				end
				S_CONV: begin
					v_q     <= conv_q;
					sat_q   <= conv_sat;
					state_q <= S_MLO;
				end
				S_MLO: begin
					plo_q   <= prod;
					state_q <= S_MHI;
				end
				S_MHI: begin
					phi_q   <= prod;
					state_q <= S_SCL;
				end
				S_SCL: begin
					if (phi_q[63:47] != 17'd0 || st > slim) begin
						v_q   <= slim;
						sat_q <= 1'b1;
					end else begin
						v_q <= sneg ? (64'd0 - st) : st;
					end
					state_q <= S_ADD;
				end
				S_ADD: begin
					cur_q <= cur_nx;
					bif_q <= '0;
					acc_q <= '0;
					if (cur_nx < n) begin
						state_q <= S_IDLE;
					end else begin
						di_q    <= '0;
						pend_q  <= 1'b0;
						state_q <= S_DRD;
					end
				end
				S_DRD: begin
					state_q <= S_DCHK;
				end
				S_DCHK: begin
					if (lay.padding || !pend_q || can_load) begin
						if (!lay.padding) begin
							if (pend_q) begin
								oidx_q  <= 4'(pend_idx_q);
								oval_q  <= pend_val_q;
								osat_q  <= pend_sat_q;
								ofn_q   <= fcnt_q;
								olast_q <= 1'b0;
							end
							pend_q     <= 1'b1;
							pend_idx_q <= di_q[IDX_W-1:0];
							pend_val_q <= dec_rd_q[63:0];
							pend_sat_q <= dec_rd_q[64];
						end
						di_q    <= di_nx;
						state_q <= (di_nx < n) ? S_DRD : S_DFIN;
					end
				end
				S_DFIN: begin
					if (!pend_q || can_load) begin
						if (pend_q) begin
							oidx_q  <= 4'(pend_idx_q);
							oval_q  <= pend_val_q;
							osat_q  <= pend_sat_q;
							ofn_q   <= fcnt_q;
							olast_q <= 1'b1;
						end
						pend_q  <= 1'b0;
						fcnt_q  <= fcnt_q + 32'd1;
						cur_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// register writes drop the partial frame
			if (cfg_acc) begin
				case (cfg.index)
					REG_NUM_FIELDS: num_q <= cfg.data;
					REG_DEFAULT_BE: dbe_q <= cfg.data[0];
					default: ;
				endcase
				cur_q <= '0;
				bif_q <= '0;
				acc_q <= '0;
			end
		end
	end

endmodule

### hdl/ffd_to_fixed.sv
`timescale 1ns / 1ps

module ffd_to_fixed (
	input  logic [63:0] raw,
	input  logic [3:0]  ftype,
	output logic [63:0] q,
	output logic        sat
);
	import ffd_pkg::*;

	logic               neg;
	logic [10:0]        e;
	logic [51:0]        m;
	logic               e_max;
	logic               norm;
	logic [52:0]        sig;
	logic signed [12:0] mbits;
	logic signed [12:0] bias;
	logic signed [12:0] k;
	logic signed [12:0] s;
	logic signed [12:0] rs;
	logic [63:0]        mag;
	logic               ovf;
	logic               is64;

	// unpack float fields and place the significand
	always_comb begin
		is64 = (ftype == TY_F64);
		if (is64) begin
			neg   = raw[63];
			e     = raw[62:52];
			m     = raw[51:0];
			e_max = &raw[62:52];
			mbits = 13'sd52;
			bias  = 13'sd1023;
		end else begin
			neg   = raw[31];
			e     = {3'b0, raw[30:23]};
			m     = {29'b0, raw[22:0]};
			e_max = &raw[30:23];
			mbits = 13'sd23;
			bias  = 13'sd127;
		end
		norm = (e != 11'd0);
		sig  = {1'b0, m};
		if (norm) begin
			if (is64)
				sig[52] = 1'b1;
			else
				sig[23] = 1'b1;
		end
		// k is the weight of the top significand bit in the Q48.16 word
		k  = (norm ? $signed({2'b0, e}) : 13'sd1) - bias + 13'sd16;
		s  = k - mbits;
		rs = -s;
		if (neg)
			ovf = norm && ((k > 13'sd63) || ((k == 13'sd63) && (m != 52'd0)));
		else
			ovf = norm && (k > 13'sd62);
		if (s >= 13'sd0)
			mag = {11'b0, sig} << s[5:0];
		else if (rs >= 13'sd64)
			mag = 64'd0;
		else
			mag = {11'b0, sig} >> rs[5:0];
	end

	// select the conversion by type
	always_comb begin
		q   = 64'd0;
		sat = 1'b0;
		case (ftype)
			TY_U8:   q = {40'b0, raw[7:0], 16'b0};
			TY_U16:  q = {32'b0, raw[15:0], 16'b0};
			TY_U32:  q = {16'b0, raw[31:0], 16'b0};
			TY_I8:   q = {{40{raw[7]}}, raw[7:0], 16'b0};
			TY_I16:  q = {{32{raw[15]}}, raw[15:0], 16'b0};
			TY_I32:  q = {{16{raw[31]}}, raw[31:0], 16'b0};
			TY_BOOL: q = (raw != 64'd0) ? 64'h1_0000 : 64'd0;
			TY_F32, TY_F64: begin
				if (e_max) begin
					sat = 1'b1;
					q   = (m != 52'd0) ? 64'd0 : (neg ? Q_MIN : Q_MAX);
				end else if (ovf) begin
					sat = 1'b1;
					q   = neg ? Q_MIN : Q_MAX;
				end else begin
					q = neg ? (64'd0 - mag) : mag;
				end
			end
			default: q = 64'd0;
		endcase
	end

endmodule
